FILE: hw/rtl/sfu_pkg.sv
package sfu_pkg;

   // default sizes
   localparam int PAGE_BYTES_DEF       = 64;
   localparam int PAGES_PER_SECTOR_DEF = 16;

   // job queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;

   // link constants
   localparam logic [7:0]  MAGIC_FIRST   = 8'h46;
   localparam logic [7:0]  MAGIC_SECOND  = 8'h93;
   localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

   // port widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_USER_W  = 3;

   // event codes
   localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
   localparam logic [1:0] CMD_TX_READY = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_TX     = 3'd0;
   localparam logic [2:0] KIND_PREP   = 3'd1;
   localparam logic [2:0] KIND_ERASE  = 3'd2;
   localparam logic [2:0] KIND_WRITE  = 3'd3;
   localparam logic [2:0] KIND_REBOOT = 3'd4;
   localparam logic [2:0] KIND_START  = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_PAGE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 2'd2;

   // protocol phase of the update
   typedef enum logic [2:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_COUNT,
      PH_RECV,
      PH_ECHO,
      PH_REPLY,
      PH_HALT
   } phase_type;

   // front sequencer
   typedef enum logic [2:0] {
      FS_IDLE,
      FS_ECHO_RD,
      FS_CMT_RD,
      FS_CMT_WR,
      FS_CMT_ACK
   } front_state_type;

   // back sequencer: which result of the current job goes out next
   typedef enum logic [1:0] {
      BK_EMPTY,
      BK_STEP0,
      BK_STEP1,
      BK_STEP2
   } back_state_type;

   // job operations
   typedef enum logic [2:0] {
      OP_TX,
      OP_TX_REBOOT,
      OP_START,
      OP_PREP,
      OP_WRITE
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [63:0] payload;
      logic [12:0] page;
      logic [2:0]  word;
      logic        last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic job_type make_job(job_op_type op, logic [63:0] payload,
                                        logic [12:0] page, logic [2:0] word,
                                        logic last);
      job_type j;
      j.op      = op;
      j.payload = payload;
      j.page    = page;
      j.word    = word;
      j.last    = last;
      return j;
   endfunction

endpackage

FILE: hw/rtl/sfu_job_queue.sv
module sfu_job_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sfu_pkg::job_type          push_job,
   input  logic                      pop,
   output sfu_pkg::job_type          head,
   output sfu_pkg::queue_status_type status
);
   import sfu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type          jobs_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign head         = jobs_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         jobs_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/sfu_front.sv
module sfu_front #(
   parameter int PAGE_BYTES = sfu_pkg::PAGE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sfu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfu_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [sfu_pkg::REQ_USER_W-1:0]     req_tuser,
   input  sfu_pkg::queue_status_type          q_status,
   output logic                               push,
   output sfu_pkg::job_type                   push_job
);
   import sfu_pkg::*;

   localparam int WORDS   = (PAGE_BYTES + 7) / 8;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W   = $clog2(PAGE_BYTES) + 1;
   localparam logic [IDX_W-1:0]   IDX_END   = IDX_W'(PAGE_BYTES);
   localparam logic [WORD_AW-1:0] WORD_LAST = WORD_AW'(WORDS - 1);

   // configuration
   logic [7:0]  escape_ff;
   logic [11:0] base_page_ff;
   logic [31:0] timeout_ff;

   // protocol state
   phase_type       phase_ff, phase_in;
   front_state_type seq_ff, seq_in;
   logic [7:0]       total_ff, total_in;
   logic [7:0]       done_ff, done_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             skip_ff, skip_in;
   logic             stuff_ff, stuff_in;
   logic [31:0]      tick_ff, tick_in;
   logic [WORD_AW-1:0] word_ff, word_in;

   // page store, one 64-bit word per row
   logic [63:0] store_ff [WORDS];
   logic [63:0] rd_ff;
   logic               mem_we;
   logic [WORD_AW-1:0] mem_waddr;
   logic [2:0]         mem_lane;
   logic               mem_re;
   logic [WORD_AW-1:0] mem_raddr;

   logic        accept;
   logic        idle_phase;
   logic [7:0]  rx;
   logic [1:0]  cmd;
   logic [12:0] page;
   logic [7:0]  echo_byte;
   logic [7:0]  done_next;
   logic [31:0] tick_sat;
   logic [63:0] word_data;

   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign cmd        = req_tuser;
   assign idle_phase = (phase_ff == PH_MAGIC0) || (phase_ff == PH_MAGIC1) ||
                       (phase_ff == PH_COUNT);
   assign page       = 13'(base_page_ff) + 13'(done_ff);
   assign echo_byte  = rd_ff[{idx_ff[2:0], 3'b000} +: 8];
   assign done_next  = done_ff + 8'd1;
   assign tick_sat   = (tick_ff == 32'hFFFF_FFFF) ? tick_ff : tick_ff + 32'd1;

   // bytes past the end of the page read as zero
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         if ((int'(word_ff) * 8 + b) < PAGE_BYTES) begin
            word_data[b*8 +: 8] = rd_ff[b*8 +: 8];
         end else begin
            word_data[b*8 +: 8] = 8'd0;
         end
      end
   end

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         FS_IDLE: begin
            if (accept && cmd == CMD_TX_READY && phase_ff == PH_ECHO && !stuff_ff) begin
               seq_in = FS_ECHO_RD;
            end else if (accept && cmd == CMD_RX_BYTE && phase_ff == PH_REPLY &&
                         rx != 8'd0) begin
               seq_in = FS_CMT_RD;
            end
         end
         FS_ECHO_RD: begin
            if (!q_status.full) begin
               seq_in = FS_IDLE;
            end
         end
         FS_CMT_RD: begin
            seq_in = FS_CMT_WR;
         end
         FS_CMT_WR: begin
            if (!q_status.full) begin
               seq_in = (word_ff == WORD_LAST) ? FS_CMT_ACK : FS_CMT_RD;
            end
         end
         FS_CMT_ACK: begin
            if (!q_status.full) begin
               seq_in = FS_IDLE;
            end
         end
         default: seq_in = FS_IDLE;
      endcase
   end

   // sequencer outputs: handshake, job pushes, store access
   always_comb begin
      req_tready = (seq_ff == FS_IDLE) && !q_status.full;
      push       = 1'b0;
      push_job   = make_job(OP_TX, 64'd0, 13'd0, 3'd0, 1'b0);
      mem_we     = 1'b0;
      mem_waddr  = WORD_AW'(idx_ff >> 3);
      mem_lane   = idx_ff[2:0];
      mem_re     = 1'b0;
      mem_raddr  = WORD_AW'(idx_ff >> 3);
      unique case (seq_ff)
         FS_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     if (idle_phase && tick_sat >= timeout_ff) begin
                        push     = 1'b1;
                        push_job = make_job(OP_START, 64'd0, 13'd0, 3'd0, 1'b1);
                     end
                  end
                  CMD_TX_READY: begin
                     if (phase_ff == PH_ECHO) begin
                        if (stuff_ff) begin
                           push     = 1'b1;
                           push_job = make_job(OP_TX, 64'd0, 13'd0, 3'd0, 1'b1);
                        end else begin
                           mem_re = 1'b1;
                        end
                     end
                  end
                  CMD_RX_BYTE: begin
                     if (phase_ff == PH_COUNT) begin
                        push     = 1'b1;
                        push_job = make_job((rx == 8'd0) ? OP_TX_REBOOT : OP_TX,
                                            64'd1, 13'd0, 3'd0, 1'b1);
                     end else if (phase_ff == PH_RECV && !skip_ff) begin
                        mem_we = 1'b1;
                     end else if (phase_ff == PH_REPLY && rx != 8'd0) begin
                        push     = 1'b1;
                        push_job = make_job(OP_PREP, 64'd0, page, 3'd0, 1'b0);
                     end
                  end
                  default: ;
               endcase
            end
         end
         FS_ECHO_RD: begin
            if (!q_status.full) begin
               push     = 1'b1;
               push_job = make_job(OP_TX, 64'(echo_byte), 13'd0, 3'd0, 1'b1);
            end
         end
         FS_CMT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = word_ff;
         end
         FS_CMT_WR: begin
            if (!q_status.full) begin
               push     = 1'b1;
               push_job = make_job(OP_WRITE, word_data, page, 3'(word_ff), 1'b0);
            end
         end
         FS_CMT_ACK: begin
            if (!q_status.full) begin
               push     = 1'b1;
               push_job = make_job((done_next == total_ff) ? OP_TX_REBOOT : OP_TX,
                                   64'd1, 13'd0, 3'd0, 1'b1);
            end
         end
         default: ;
      endcase
   end

   // protocol state updates
   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      done_in  = done_ff;
      idx_in   = idx_ff;
      skip_in  = skip_ff;
      stuff_in = stuff_ff;
      tick_in  = tick_ff;
      word_in  = word_ff;
      unique case (seq_ff)
         FS_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     if (idle_phase) begin
                        tick_in = tick_sat;
                        if (tick_sat >= timeout_ff) begin
                           phase_in = PH_HALT;
                        end
                     end
                  end
                  CMD_TX_READY: begin
                     // a pending stuffed zero goes out on its own
                     if (phase_ff == PH_ECHO && stuff_ff) begin
                        stuff_in = 1'b0;
                        if (idx_ff >= IDX_END) begin
                           phase_in = PH_REPLY;
                        end
                     end
                  end
                  CMD_RX_BYTE: begin
                     priority case (phase_ff)
                        PH_MAGIC0: begin
                           if (rx == MAGIC_FIRST) begin
                              phase_in = PH_MAGIC1;
                           end
                        end
                        PH_MAGIC1: begin
                           phase_in = (rx == MAGIC_SECOND) ? PH_COUNT : PH_MAGIC0;
                        end
                        PH_COUNT: begin
                           total_in = rx;
                           done_in  = 8'd0;
                           if (rx == 8'd0) begin
                              phase_in = PH_HALT;
                           end else begin
                              phase_in = PH_RECV;
                              idx_in   = '0;
                              skip_in  = 1'b0;
                           end
                        end
                        PH_RECV: begin
                           // the byte after an escape byte is dropped
                           if (skip_ff) begin
                              skip_in = 1'b0;
                           end else begin
                              skip_in = (rx == escape_ff);
                              idx_in  = idx_ff + 1'b1;
                           end
                           if (!skip_in && idx_in >= IDX_END) begin
                              phase_in = PH_ECHO;
                              idx_in   = '0;
                              stuff_in = 1'b0;
                           end
                        end
                        PH_REPLY: begin
                           if (rx != 8'd0) begin
                              word_in = '0;
                           end else begin
                              phase_in = PH_RECV;
                              idx_in   = '0;
                              skip_in  = 1'b0;
                           end
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         FS_ECHO_RD: begin
            if (!q_status.full) begin
               stuff_in = (echo_byte == escape_ff);
               idx_in   = idx_ff + 1'b1;
               if (!stuff_in && idx_in >= IDX_END) begin
                  phase_in = PH_REPLY;
               end
            end
         end
         FS_CMT_WR: begin
            if (!q_status.full && word_ff != WORD_LAST) begin
               word_in = word_ff + 1'b1;
            end
         end
         FS_CMT_ACK: begin
            if (!q_status.full) begin
               done_in = done_next;
               if (done_next == total_ff) begin
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_RECV;
                  idx_in   = '0;
                  skip_in  = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // page store and its registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr][{mem_lane, 3'b000} +: 8] <= rx;
      end
      if (mem_re) begin
         rd_ff <= store_ff[mem_raddr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= 8'd0;
         base_page_ff <= 12'd0;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ESCAPE:    escape_ff    <= csr_wdata[7:0];
            CSR_BASE_PAGE: base_page_ff <= csr_wdata[11:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= FS_IDLE;
         phase_ff <= PH_MAGIC0;
         total_ff <= 8'd0;
         done_ff  <= 8'd0;
         idx_ff   <= '0;
         skip_ff  <= 1'b0;
         stuff_ff <= 1'b0;
         tick_ff  <= 32'd0;
         word_ff  <= '0;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         total_ff <= total_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
         skip_ff  <= skip_in;
         stuff_ff <= stuff_in;
         tick_ff  <= tick_in;
         word_ff  <= word_in;
      end
   end

endmodule

FILE: hw/rtl/sfu_back.sv
module sfu_back #(
   parameter int PAGES_PER_SECTOR = sfu_pkg::PAGES_PER_SECTOR_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfu_pkg::job_type                head,
   input  sfu_pkg::queue_status_type       q_status,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [sfu_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);
   import sfu_pkg::*;

   // page / PAGES_PER_SECTOR as a multiply by a rounded-up reciprocal
   localparam int SEC_SHIFT = 19;
   localparam logic [19:0] SEC_RECIP =
      20'((2**SEC_SHIFT + PAGES_PER_SECTOR - 1) / PAGES_PER_SECTOR);

   back_state_type state_ff, state_in;
   job_type        cur_ff;
   logic [8:0]     sector_ff;
   logic [32:0]    sec_prod;

   logic           rsp_valid_ff;
   logic [63:0]    rsp_payload_ff;
   logic [8:0]     rsp_sector_ff;
   logic [12:0]    rsp_page_ff;
   logic [2:0]     rsp_word_ff;
   logic [2:0]     rsp_kind_ff;
   logic           rsp_last_ff;

   logic        out_free;
   logic        emit;
   logic        final0;
   logic [2:0]  r_kind;
   logic [63:0] r_payload;
   logic [8:0]  r_sector;
   logic [12:0] r_page;
   logic [2:0]  r_word;
   logic        r_last;

   assign sec_prod = 33'(head.page) * 33'(SEC_RECIP);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign final0   = (cur_ff.op == OP_TX) || (cur_ff.op == OP_START) ||
                     (cur_ff.op == OP_WRITE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_EMPTY: begin
            if (!q_status.empty) begin
               state_in = BK_STEP0;
            end
         end
         BK_STEP0: begin
            if (out_free) begin
               state_in = final0 ? BK_EMPTY : BK_STEP1;
            end
         end
         BK_STEP1: begin
            if (out_free) begin
               state_in = (cur_ff.op == OP_TX_REBOOT) ? BK_EMPTY : BK_STEP2;
            end
         end
         BK_STEP2: begin
            if (out_free) begin
               state_in = BK_EMPTY;
            end
         end
         default: state_in = BK_EMPTY;
      endcase
   end

   // outputs: pop, emit and the result of the current step
   always_comb begin
      pop       = (state_ff == BK_EMPTY) && !q_status.empty;
      emit      = (state_ff != BK_EMPTY) && out_free;
      r_kind    = KIND_TX;
      r_payload = 64'd0;
      r_sector  = 9'd0;
      r_page    = 13'd0;
      r_word    = 3'd0;
      r_last    = 1'b0;
      unique case (state_ff)
         BK_STEP0: begin
            r_last = final0 ? cur_ff.last : 1'b0;
            unique case (cur_ff.op)
               OP_TX, OP_TX_REBOOT: begin
                  r_kind    = KIND_TX;
                  r_payload = cur_ff.payload;
               end
               OP_START: begin
                  r_kind = KIND_START;
               end
               OP_PREP: begin
                  r_kind   = KIND_PREP;
                  r_sector = sector_ff;
               end
               OP_WRITE: begin
                  r_kind    = KIND_WRITE;
                  r_payload = cur_ff.payload;
                  r_page    = cur_ff.page;
                  r_word    = cur_ff.word;
               end
               default: ;
            endcase
         end
         BK_STEP1: begin
            if (cur_ff.op == OP_TX_REBOOT) begin
               r_kind = KIND_REBOOT;
               r_last = cur_ff.last;
            end else begin
               r_kind = KIND_ERASE;
               r_page = cur_ff.page;
            end
         end
         BK_STEP2: begin
            r_kind   = KIND_PREP;
            r_sector = sector_ff;
         end
         default: ;
      endcase
   end

   // current job
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff    <= head;
         sector_ff <= sec_prod[SEC_SHIFT +: 9];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= r_kind;
         rsp_payload_ff <= r_payload;
         rsp_sector_ff  <= r_sector;
         rsp_page_ff    <= r_page;
         rsp_word_ff    <= r_word;
         rsp_last_ff    <= r_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_word_ff, rsp_page_ff, rsp_sector_ff, rsp_payload_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/serial_flash_update_receiver.sv
// channel  | direction | handshake              | contents
// csr      | in        | csr_we                 | csr_index, csr_wdata
// req      | in        | req_tvalid/req_tready  | tuser command, tdata rx_byte
// rsp      | out       | rsp_tvalid/rsp_tready  | tuser kind, tdata payload..word_offset,
//          |           |                        | tlast on the final result of an item
//
// A received byte or a tick is taken straight away; a transmitter-ready event
// that reads the page store then pushes its byte from the registered read.
// A nonzero reply holds the front while it reads and pushes each 64-bit
// store word in turn, then pushes the ack.
// The back loads each job, then sends one result per cycle while the
// receiver takes them. Reset is synchronous; the page store is not cleared.
// A four-entry job queue parts the front from the result register, so either
// side stalls without losing an item.
module serial_flash_update_receiver #(
   parameter int PAGE_BYTES       = sfu_pkg::PAGE_BYTES_DEF,
   parameter int PAGES_PER_SECTOR = sfu_pkg::PAGES_PER_SECTOR_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sfu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rx_byte [7:0]
   input  logic [sfu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command [1:0]
   input  logic [sfu_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // payload [63:0], sector [72:64], flash_page [85:73], word_offset [88:86]
   output logic [sfu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind [2:0]
   output logic [sfu_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);
   import sfu_pkg::*;

   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head;
   queue_status_type q_status;

   // accepts and classifies items
   sfu_front #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   // jobs in flight
   sfu_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // expands jobs into result items
   sfu_back #(
      .PAGES_PER_SECTOR (PAGES_PER_SECTOR)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/sfu_checker.sv
module sfu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sfu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [sfu_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input logic                             rsp_tlast
);
   import sfu_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // only transmit and write data carry a payload
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_TX && rsp_tuser != KIND_WRITE |->
         rsp_tdata[63:0] == 64'd0)
      else $error("payload on a result kind that has none");

   // word offset only on write data
   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_WRITE |-> rsp_tdata[88:86] == 3'd0)
      else $error("word offset outside write data");

   // reboot and start application end the stream
   a_halt_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == KIND_REBOOT || rsp_tuser == KIND_START)
         |-> rsp_tlast ##1 !rsp_tvalid)
      else $error("result after reboot or start application");

endmodule

bind serial_flash_update_receiver sfu_checker u_sfu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sfu_pkg::*;

   localparam int PAGE_BYTES       = PAGE_BYTES_DEF;
   localparam int PAGES_PER_SECTOR = PAGES_PER_SECTOR_DEF;
   // the fourth command code means nothing to the block
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // cycles to let the block drain once nothing is expected
   localparam int SETTLE_CYCLES = 32;

   // one flash operation or transmit byte leaving the block
   typedef struct {
      logic [2:0]  kind;
      logic [63:0] payload;
      logic [8:0]  sector;
      logic [12:0] flash_page;
      logic [2:0]  word_offset;
      logic        last;
   } flash_op_type;

   // tracks the update protocol and the flash operations it must cause
   class update_scoreboard;
      logic [7:0]   escape_value;
      logic [11:0]  first_page;
      logic [31:0]  tick_limit;
      phase_type    stage;
      logic [7:0]   page_count;
      logic [7:0]   pages_committed;
      int           store_index;
      bit           drop_next;
      bit           stuff_next;
      logic [7:0]   page_store [64];
      logic [31:0]  tick_total;
      flash_op_type expected_ops [$];
      int           error_count;

      function new();
         escape_value    = 8'h00;
         first_page      = 12'h000;
         tick_limit      = TIMEOUT_RESET;
         stage           = PH_MAGIC0;
         page_count      = 8'd0;
         pages_committed = 8'd0;
         store_index     = 0;
         drop_next       = 1'b0;
         stuff_next      = 1'b0;
         tick_total      = 32'd0;
         error_count     = 0;
         foreach (page_store[i]) page_store[i] = 8'h00;
      endfunction

      function void set_config(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_ESCAPE:    escape_value = value[7:0];
            CSR_BASE_PAGE: first_page = value[11:0];
            CSR_TIMEOUT:   tick_limit = value;
            default: ;
         endcase
      endfunction

      function void push_op(logic [2:0] kind, logic [63:0] payload, logic [8:0] sector,
                            logic [12:0] page, logic [2:0] word_offset);
         flash_op_type op;
         op.kind        = kind;
         op.payload     = payload;
         op.sector      = sector;
         op.flash_page  = page;
         op.word_offset = word_offset;
         op.last        = 1'b0;
         expected_ops.push_back(op);
      endfunction

      // prepare, erase, prepare, the data words and the ack for one page, then a reboot after the last page
      function void commit_page();
         logic [12:0] page;
         logic [8:0]  sector;
         logic [63:0] packed_word;
         int          words;
         page   = 13'(first_page) + 13'(pages_committed);
         sector = 9'(page / PAGES_PER_SECTOR);
         words  = (PAGE_BYTES + 7) / 8;
         if (words > 8) words = 8;
         push_op(KIND_PREP, 64'd0, sector, 13'd0, 3'd0);
         push_op(KIND_ERASE, 64'd0, 9'd0, page, 3'd0);
         push_op(KIND_PREP, 64'd0, sector, 13'd0, 3'd0);
         for (int w = 0; w < words; w++) begin
            packed_word = 64'd0;
            for (int b = 0; b < 8; b++) begin
               if (w * 8 + b < PAGE_BYTES) packed_word[8*b +: 8] = page_store[(w * 8 + b) % 64];
            end
            push_op(KIND_WRITE, packed_word, 9'd0, page, 3'(w));
         end
         push_op(KIND_TX, 64'd1, 9'd0, 13'd0, 3'd0);
         pages_committed = pages_committed + 8'd1;
         if (pages_committed == page_count) begin
            push_op(KIND_REBOOT, 64'd0, 9'd0, 13'd0, 3'd0);
            stage = PH_HALT;
         end else begin
            stage       = PH_RECV;
            store_index = 0;
            drop_next   = 1'b0;
         end
      endfunction

      // advance the protocol by one accepted event
      function void apply_event(logic [1:0] cmd, logic [7:0] rx);
         int           before_count;
         bit           in_idle;
         logic [7:0]   echoed;
         flash_op_type final_op;
         before_count = expected_ops.size();
         in_idle = (stage == PH_MAGIC0) || (stage == PH_MAGIC1) || (stage == PH_COUNT);
         case (cmd)
            CMD_TICK: begin
               if (in_idle) begin
                  if (tick_total != 32'hFFFF_FFFF) tick_total = tick_total + 32'd1;
                  if (tick_total >= tick_limit) begin
                     push_op(KIND_START, 64'd0, 9'd0, 13'd0, 3'd0);
                     stage = PH_HALT;
                  end
               end
            end
            CMD_TX_READY: begin
               if (stage == PH_ECHO) begin
                  if (stuff_next) begin
                     stuff_next = 1'b0;
                     push_op(KIND_TX, 64'd0, 9'd0, 13'd0, 3'd0);
                  end else begin
                     echoed = page_store[store_index % 64];
                     push_op(KIND_TX, {56'd0, echoed}, 9'd0, 13'd0, 3'd0);
                     if (echoed == escape_value) stuff_next = 1'b1;
                     store_index++;
                  end
                  if (!stuff_next && store_index >= PAGE_BYTES) stage = PH_REPLY;
               end
            end
            CMD_RX_BYTE: begin
               case (stage)
                  PH_MAGIC0: if (rx == MAGIC_FIRST) stage = PH_MAGIC1;
                  PH_MAGIC1: stage = (rx == MAGIC_SECOND) ? PH_COUNT : PH_MAGIC0;
                  PH_COUNT: begin
                     page_count      = rx;
                     pages_committed = 8'd0;
                     push_op(KIND_TX, 64'd1, 9'd0, 13'd0, 3'd0);
                     if (page_count == 8'd0) begin
                        push_op(KIND_REBOOT, 64'd0, 9'd0, 13'd0, 3'd0);
                        stage = PH_HALT;
                     end else begin
                        stage       = PH_RECV;
                        store_index = 0;
                        drop_next   = 1'b0;
                     end
                  end
                  PH_RECV: begin
                     if (drop_next) begin
                        drop_next = 1'b0;
                     end else begin
                        page_store[store_index % 64] = rx;
                        if (rx == escape_value) drop_next = 1'b1;
                        store_index++;
                     end
                     if (!drop_next && store_index >= PAGE_BYTES) begin
                        stage       = PH_ECHO;
                        store_index = 0;
                        stuff_next  = 1'b0;
                     end
                  end
                  PH_REPLY: begin
                     if (rx != 8'd0) begin
                        commit_page();
                     end else begin
                        stage       = PH_RECV;
                        store_index = 0;
                        drop_next   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         // flag the final operation caused by this item
         if (expected_ops.size() > before_count) begin
            final_op = expected_ops.pop_back();
            final_op.last = 1'b1;
            expected_ops.push_back(final_op);
         end
      endfunction

      function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
         if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            error_count++;
         end
      endfunction

      function void check_op(logic [RSP_USER_W-1:0] kind, logic [RSP_DATA_W-1:0] data,
                             logic last);
         flash_op_type want;
         if (expected_ops.size() == 0) begin
            $error("unexpected result: kind %0d, payload 0x%0h", kind, data[63:0]);
            error_count++;
            return;
         end
         want = expected_ops.pop_front();
         compare_field("kind", 64'(want.kind), 64'(kind));
         compare_field("payload", want.payload, data[63:0]);
         compare_field("sector", 64'(want.sector), 64'(data[72:64]));
         compare_field("flash_page", 64'(want.flash_page), 64'(data[85:73]));
         compare_field("word_offset", 64'(want.word_offset), 64'(data[88:86]));
         compare_field("last", 64'(want.last), 64'(last));
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;

   update_scoreboard board;
   bit               idle_on = 1'b1;

   serial_flash_update_receiver u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // results are checked before the item of the same edge is applied
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_op(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) board.apply_event(req_tuser, req_tdata);
      end
   end

   // receiver stalls in bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // present one item and hold it until accepted; called at a falling edge
   task automatic send_item(logic [1:0] cmd, logic [7:0] rx);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // an event the block ignores in the current phase
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_item(CMD_TICK, 8'($urandom));
         1: send_item((board.stage == PH_ECHO) ? CMD_RX_BYTE : CMD_TX_READY, 8'($urandom));
         default: send_item(CMD_UNUSED, 8'($urandom));
      endcase
   endtask

   // hold the sender until every expected result is out and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.expected_ops.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_config(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [7:0] rx;
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // startup settings: top escape and base, short timeout
      write_register(CSR_ESCAPE, 32'hFF);
      write_register(CSR_BASE_PAGE, 32'hFFF);
      write_register(CSR_TIMEOUT, 32'd40);

      // idle phase: stray events and broken preambles
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TX_READY, 8'hFF);
      send_item(CMD_UNUSED, 8'hFF);
      send_item(CMD_RX_BYTE, 8'h00);
      send_item(CMD_RX_BYTE, 8'hFF);
      send_item(CMD_RX_BYTE, MAGIC_FIRST);
      send_item(CMD_RX_BYTE, MAGIC_FIRST);
      send_item(CMD_RX_BYTE, MAGIC_SECOND);
      send_item(CMD_RX_BYTE, MAGIC_FIRST);
      send_item(CMD_RX_BYTE, 8'h00);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_RX_BYTE, MAGIC_FIRST);
      send_item(CMD_RX_BYTE, MAGIC_SECOND);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TX_READY, 8'h00);
      send_item(CMD_UNUSED, MAGIC_FIRST);
      send_item(CMD_RX_BYTE, 8'd1);

      // ticks no longer count once pages flow, even with a zero timeout
      write_register(CSR_TIMEOUT, 32'd0);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'hFF);

      // a single page whose last byte is an escape byte
      idle_on = 1'b1;
      while (board.stage == PH_RECV) begin
         if ($urandom_range(0, 19) == 0) send_noise();
         if (board.drop_next)
            rx = 8'($urandom);
         else if (board.store_index == PAGE_BYTES - 1)
            rx = board.escape_value;
         else if ($urandom_range(0, 15) == 0)
            rx = board.escape_value;
         else
            rx = 8'($urandom);
         send_item(CMD_RX_BYTE, rx);
      end
      while (board.stage == PH_ECHO) begin
         // no idling over the second half of the echo and the commit
         idle_on = (board.store_index < PAGE_BYTES / 2);
         if ($urandom_range(0, 19) == 0) send_noise();
         send_item(CMD_TX_READY, 8'($urandom));
      end
      send_item(CMD_RX_BYTE, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255)));

      // the block has halted: stray events must stay silent
      idle_on = 1'b0;
      send_item(CMD_RX_BYTE, MAGIC_FIRST);
      send_item(CMD_TX_READY, 8'h00);
      send_item(CMD_TICK, 8'h00);

      settle();
      if (board.error_count == 0 && board.expected_ops.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
